/* sv/cmwc_pkg.sv */
`default_nettype none
package cmwc_pkg;

    // Lag table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Generator constants.
    localparam logic [14:0] MULT_CMWC = 15'd18782;
    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] CMWC_BASE = 32'hfffffffe;

    // Rejection limit for one uniform item.
    localparam int          TRY_W       = 17;
    localparam logic [16:0] MAX_RETRIES = 17'd65536;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_INIT    = 2'd0;
    localparam logic [1:0] FUNC_RAW     = 2'd1;
    localparam logic [1:0] FUNC_UNIFORM = 2'd2;

    // Register index of the seed.
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_DRAW_RD,
        ST_DRAW_MUL,
        ST_DRAW_FIX,
        ST_FLOOR_DIV,
        ST_MOD_DIV,
        ST_RESULT
    } cmwc_state_t;

endpackage
`default_nettype wire

/* sv/cmwc_ram.sv */
`default_nettype none
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* sv/cmwc_divider.sv */
`default_nettype none
module cmwc_divider
    import cmwc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[31]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = 32'(trial - {1'b0, d_reg});
            end else begin
                r_next = trial[31:0];
            end
            q_next   = {q_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign remainder = r_reg;

`ifndef SYNTHESIS
    // A result appears only after a full run.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");

    // The remainder stays below the divisor once a run completes.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && d_reg != 32'd0) |-> (r_reg < d_reg))
        else $error("remainder not below divisor");

    // A run has 32 steps, so done never follows start directly.
    a_no_early_done: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done_reg)
        else $error("divider finished too early");
`endif

endmodule
`default_nettype wire

/* sv/cmwc4096_random_generator.sv */
`default_nettype none
// Channel  Ports                          Moves
// input    s_valid s_ready s_func s_bound one command item
// result   m_valid m_ready m_value        one result item per command
//          m_carry_now
// config   psel penable pwrite paddr      seed register at byte address 0
//          pwdata prdata pready
//
// After reset the lag table is cleared, one entry a cycle, with s_ready low.
// A raw item takes a table read, a multiply and a fix-up step, then the
// result state loads the output register. A uniform item finds the rejection
// floor with the 32-step divider, draws with read, multiply and fix-up steps
// and takes the final modulo with the divider. An init item writes one table
// entry a cycle. The next item is taken the cycle after a result is loaded.
// A stalled result holds the block in its result state.
module cmwc4096_random_generator
    import cmwc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [31:0] s_bound,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_value,
    output logic [31:0]      m_carry_now,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cmwc_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      carry_reg, carry_next;
    logic [31:0]      seed_reg;
    logic [31:0]      x_reg, x_next;
    logic [1:0]       func_reg, func_next;
    logic [31:0]      bound_reg, bound_next;
    logic [31:0]      floor_reg, floor_next;
    logic [31:0]      value_reg, value_next;
    logic [46:0]      prod_reg, prod_next;
    logic [TRY_W-1:0] tries_reg, tries_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_value_reg, m_value_next;
    logic [31:0]      m_carry_reg, m_carry_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    logic             div_start, div_done;
    logic [31:0]      div_dividend, div_divisor, div_rem;

    logic [47:0]      fix_sum;
    logic [32:0]      fix_low;
    logic [31:0]      fix_carry, fix_word;
    logic [TRY_W-1:0] tries_inc;

    cmwc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cmwc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Seed register write and read.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_SEED) begin
            seed_reg <= pwdata;
        end
    end

    // Carry fix-up of one draw.
    always_comb begin
        fix_sum   = 48'(prod_reg) + 48'(carry_reg);
        fix_carry = 32'(fix_sum[47:32]);
        fix_low   = 33'(fix_sum[31:0]) + 33'(fix_carry);
        if (fix_low[32]) begin
            fix_low   = 33'(fix_low[31:0]) + 33'd1;
            fix_carry = fix_carry + 32'd1;
        end
        fix_word  = CMWC_BASE - fix_low[31:0];
        tries_inc = tries_reg + TRY_W'(1);
    end

    // Command sequencer.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        carry_next   = carry_reg;
        x_next       = x_reg;
        func_next    = func_reg;
        bound_next   = bound_reg;
        floor_next   = floor_reg;
        value_next   = value_reg;
        prod_next    = prod_reg;
        tries_next   = tries_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_carry_next = m_carry_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = fix_word;
        ram_raddr    = idx_reg + IDX_W'(1);
        div_start    = 1'b0;
        div_dividend = 32'd0 - bound_reg;
        div_divisor  = bound_reg;
        s_ready      = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = s_func;
                    bound_next = s_bound;
                    value_next = '0;
                    case (s_func)
                        FUNC_INIT: begin
                            cnt_next   = '0;
                            x_next     = seed_reg;
                            carry_next = seed_reg;
                            state_next = ST_INIT;
                        end
                        FUNC_RAW: begin
                            state_next = ST_DRAW_RD;
                        end
                        FUNC_UNIFORM: begin
                            if (s_bound < 32'd2) begin
                                state_next = ST_RESULT;
                            end else begin
                                div_start    = 1'b1;
                                div_dividend = 32'd0 - s_bound;
                                div_divisor  = s_bound;
                                state_next   = ST_FLOOR_DIV;
                            end
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = x_reg;
                x_next    = x_reg * LCG_MUL + LCG_ADD;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_RESULT;
                end
            end
            ST_DRAW_RD: begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_DRAW_MUL;
            end
            ST_DRAW_MUL: begin
                prod_next  = 47'(ram_rdata) * 47'(MULT_CMWC);
                state_next = ST_DRAW_FIX;
            end
            ST_DRAW_FIX: begin
                ram_we     = 1'b1;
                carry_next = fix_carry;
                value_next = fix_word;
                if (func_reg == FUNC_RAW) begin
                    state_next = ST_RESULT;
                end else if (fix_word >= floor_reg || tries_inc >= MAX_RETRIES) begin
                    div_start    = 1'b1;
                    div_dividend = fix_word;
                    state_next   = ST_MOD_DIV;
                end else begin
                    tries_next = tries_inc;
                    state_next = ST_DRAW_RD;
                end
            end
            ST_FLOOR_DIV: begin
                if (div_done) begin
                    floor_next = div_rem;
                    tries_next = '0;
                    state_next = ST_DRAW_RD;
                end
            end
            ST_MOD_DIV: begin
                if (div_done) begin
                    value_next = div_rem;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = value_reg;
                    m_carry_next = carry_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= IDX_W'(TABLE_DEPTH - 1);
            cnt_reg     <= '0;
            carry_reg   <= '0;
            tries_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            carry_reg   <= carry_next;
            tries_reg   <= tries_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg       <= x_next;
        func_reg    <= func_next;
        bound_reg   <= bound_next;
        floor_reg   <= floor_next;
        value_reg   <= value_next;
        prod_reg    <= prod_next;
        m_value_reg <= m_value_next;
        m_carry_reg <= m_carry_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_carry_now = m_carry_reg;

`ifndef SYNTHESIS
    // No item is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("item accepted during table clear");

    // A new result is loaded only from the result state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("result loaded outside result state");

    // The final modulo leads straight to the result state.
    a_mod_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD_DIV && div_done) |=> (state_reg == ST_RESULT))
        else $error("modulo result dropped");

    // The retry counter never passes its limit.
    a_tries_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        tries_reg < MAX_RETRIES)
        else $error("retry counter overflow");
`endif

endmodule
`default_nettype wire
